[design/u2u8_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types, constants and the UTF-8 encoder for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

    // Depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Capacity register value after reset
    localparam logic [15:0] CAP_RESET = 16'd2048;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Surrogate ranges
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;

    // Lead and continuation byte marks
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    // Range limits of the encoding lengths
    localparam logic [20:0] LIM1 = 21'h80;
    localparam logic [20:0] LIM2 = 21'h800;
    localparam logic [20:0] LIM3 = 21'h10000;

    // One request for the back end: up to four bytes or one end marker
    typedef struct packed {
        logic [3:0][7:0] seq;
        logic [1:0]      last_idx;
        logic            is_end;
        logic            byte_ok;
        logic [1:0]      status;
        logic [15:0]     count;
    } job_t;

    // Encoder result: byte 0 goes out first
    typedef struct packed {
        logic [3:0][7:0] seq;
        logic [2:0]      len;
    } enc_t;

    function automatic enc_t encode(input logic [20:0] value);
        enc_t e;
        e.seq = '0;
        if (value < LIM1) begin
            e.seq[0] = value[7:0];
            e.len    = 3'd1;
        end
        else if (value < LIM2) begin
            e.seq[0] = LEAD2 | {3'b000, value[10:6]};
            e.seq[1] = CONT | {2'b00, value[5:0]};
            e.len    = 3'd2;
        end
        else if (value < LIM3) begin
            e.seq[0] = LEAD3 | {4'b0000, value[15:12]};
            e.seq[1] = CONT | {2'b00, value[11:6]};
            e.seq[2] = CONT | {2'b00, value[5:0]};
            e.len    = 3'd3;
        end
        else begin
            e.seq[0] = LEAD4 | {5'b00000, value[20:18]};
            e.seq[1] = CONT | {2'b00, value[17:12]};
            e.seq[2] = CONT | {2'b00, value[11:6]};
            e.seq[3] = CONT | {2'b00, value[5:0]};
            e.len    = 3'd4;
        end
        return e;
    endfunction

endpackage
`default_nettype wire

[design/u2u8_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8_front
// Accepts code units, tracks per-string state and capacity, and turns each
// unit or end marker into at most one request for the back end.
// ----------------------------------------------------------------------------
module u2u8_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [15:0]     code_unit,
    input  wire logic            string_end,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [15:0]     cfg_data,
    input  wire logic            q_full,
    output logic                 push,
    output u2u8_pkg::job_t       job
);

    logic [15:0] cap_reg;
    logic        pending_reg, pending_next;
    logic [9:0]  hi_reg, hi_next;
    logic [15:0] count_reg, count_next;
    logic [1:0]  sticky_reg, sticky_next;

    logic           accept;
    logic           is_high;
    logic           is_low;
    logic [20:0]    pair_value;
    logic [20:0]    emit_value;
    u2u8_pkg::enc_t enc;
    logic [15:0]    room;
    logic           full_now;
    logic [2:0]     n_fit;
    logic [2:0]     n_m1;

    assign in_stall  = q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !q_full;

    // Classify the unit
    assign is_high = code_unit[15:10] == u2u8_pkg::HIGH_SURR_BASE[15:10];
    assign is_low  = code_unit[15:10] == u2u8_pkg::LOW_SURR_BASE[15:10];

    // Build the scalar and its encoding
    assign pair_value = {1'b0, hi_reg, code_unit[9:0]} + u2u8_pkg::SUPP_BASE;
    assign emit_value = pending_reg ? pair_value : {5'b00000, code_unit};
    assign enc        = u2u8_pkg::encode(emit_value);

    // Count the bytes that still fit
    assign room     = cap_reg - count_reg;
    assign full_now = count_reg >= cap_reg;
    always_comb
    begin
        if (full_now)
            n_fit = 3'd0;
        else if (room >= {13'd0, enc.len})
            n_fit = enc.len;
        else
            n_fit = room[2:0];
    end
    assign n_m1 = n_fit - 3'd1;

    // Next state and request
    always_comb
    begin
        logic       do_emit;
        logic [1:0] end_status;
        logic       end_ok;
        do_emit      = 1'b0;
        end_status   = sticky_reg;
        end_ok       = 1'b0;
        pending_next = pending_reg;
        hi_next      = hi_reg;
        count_next   = count_reg;
        sticky_next  = sticky_reg;
        push         = 1'b0;
        job          = '0;
        if (accept)
        begin
            if (string_end)
            begin
                if (sticky_reg == u2u8_pkg::ST_OK)
                begin
                    if (pending_reg)
                        end_status = u2u8_pkg::ST_INVALID;
                    else if (full_now)
                        end_status = u2u8_pkg::ST_FULL;
                    else
                        end_ok = 1'b1;
                end
                push         = 1'b1;
                job.is_end   = 1'b1;
                job.byte_ok  = end_ok;
                job.status   = end_status;
                job.count    = count_reg;
                pending_next = 1'b0;
                hi_next      = '0;
                count_next   = '0;
                sticky_next  = u2u8_pkg::ST_OK;
            end
            else if (sticky_reg != u2u8_pkg::ST_OK)
            begin
                // drop units until the end marker
            end
            else if (pending_reg)
            begin
                pending_next = 1'b0;
                hi_next      = '0;
                if (is_low)
                    do_emit = 1'b1;
                else
                    sticky_next = u2u8_pkg::ST_INVALID;
            end
            else if (full_now)
                sticky_next = u2u8_pkg::ST_FULL;
            else if (is_high)
            begin
                pending_next = 1'b1;
                hi_next      = code_unit[9:0];
            end
            else if (is_low)
                sticky_next = u2u8_pkg::ST_INVALID;
            else
                do_emit = 1'b1;
        end
        if (do_emit)
        begin
            count_next   = count_reg + {13'd0, n_fit};
            if (n_fit != enc.len)
                sticky_next = u2u8_pkg::ST_FULL;
            push         = n_fit != 3'd0;
            job.seq      = enc.seq;
            job.last_idx = n_m1[1:0];
        end
    end

    // Hold state and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= u2u8_pkg::CAP_RESET;
            pending_reg <= 1'b0;
            hi_reg      <= '0;
            count_reg   <= '0;
            sticky_reg  <= u2u8_pkg::ST_OK;
        end
        else
        begin
            if (cfg_valid)
                cap_reg <= cfg_data;
            pending_reg <= pending_next;
            hi_reg      <= hi_next;
            count_reg   <= count_next;
            sticky_reg  <= sticky_next;
        end
    end

endmodule
`default_nettype wire

[design/u2u8_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8_queue
// Short request queue between front and back end.
// ----------------------------------------------------------------------------
module u2u8_queue
#(
    parameter int DEPTH = u2u8_pkg::QUEUE_DEPTH
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire u2u8_pkg::job_t  push_job,
    output logic                 full,
    input  wire logic            pop,
    output logic                 q_valid,
    output u2u8_pkg::job_t       head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

    u2u8_pkg::job_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full    = cnt_reg == DEPTH_C;
    assign q_valid = cnt_reg != '0;
    assign head    = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    // Never overrun or underrun the queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("request popped from empty queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

[design/u2u8_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8_back
// Walks the head request one byte per cycle, unless stalled, into the output register.
// ----------------------------------------------------------------------------
module u2u8_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire u2u8_pkg::job_t  head,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [7:0]           utf8_byte,
    output logic                 byte_valid,
    output logic                 run_last,
    output logic                 string_done,
    output logic [1:0]           status,
    output logic [15:0]          bytes_written
);

    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic        bvalid_reg;
    logic        last_reg;
    logic        done_reg;
    logic [1:0]  status_reg;
    logic [15:0] count_reg;

    logic load;
    logic last_byte;

    assign load      = q_valid && (!out_valid_reg || !out_stall);
    assign last_byte = head.is_end || (idx_reg == head.last_idx);
    assign pop       = load && last_byte;

    // Advance the byte index and output valid
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last_byte ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= head.is_end ? 8'h00 : head.seq[idx_reg];
            bvalid_reg <= head.is_end ? head.byte_ok : 1'b1;
            last_reg   <= last_byte;
            done_reg   <= head.is_end;
            status_reg <= head.is_end ? head.status : u2u8_pkg::ST_OK;
            count_reg  <= head.is_end ? head.count : 16'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign utf8_byte     = byte_reg;
    assign byte_valid    = bvalid_reg;
    assign run_last      = last_reg;
    assign string_done   = done_reg;
    assign status        = status_reg;
    assign bytes_written = count_reg;

    // A finished string always closes its run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> last_reg)
        else $error("end result without run_last");
    // Status and count stay clear on code unit bytes
    a_clear_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_reg |-> status_reg == u2u8_pkg::ST_OK
                                       && count_reg == 16'd0 && bvalid_reg)
        else $error("code unit byte with end fields set");
    // Index returns to zero once a request is popped
    a_idx_reset: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 2'd0)
        else $error("byte index not cleared after pop");

endmodule
`default_nettype wire

[design/utf16_to_utf8_transcoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, with a capacity limit and status.
// ----------------------------------------------------------------------------
// The front end takes one request a cycle (a code unit or an end marker)
// whenever the request queue has room, updates the string state and the
// byte count at once, and queues the bytes that fit. The back end sends one
// byte per cycle through a registered output while out_stall does not hold it,
// so a unit yields up to 3 bytes, a pair up to 4 over two requests, an end
// marker one result, a unit with no byte nothing; the output byte rate sets the
// sustained throughput. Capacity is written through cfg_data, which is always
// ready, and must only change while no string request is in flight.
module utf16_to_utf8_transcoder
#(
    parameter int QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] code_unit,
    input  wire logic        string_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       utf8_byte,
    output logic             byte_valid,
    output logic             run_last,
    output logic             string_done,
    output logic [1:0]       status,
    output logic [15:0]      bytes_written,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic           q_full;
    logic           push;
    logic           pop;
    logic           q_valid;
    u2u8_pkg::job_t push_job;
    u2u8_pkg::job_t head;

    u2u8_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_unit  (code_unit),
        .string_end (string_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push),
        .job        (push_job)
    );

    u2u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    u2u8_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .utf8_byte     (utf8_byte),
        .byte_valid    (byte_valid),
        .run_last      (run_last),
        .string_done   (string_done),
        .status        (status),
        .bytes_written (bytes_written)
    );

endmodule
`default_nettype wire
